// ===== rtl/sacl_pkg.sv =====
// Shared types and constants for the set-associative cache tag lookup.
// Used by sacl_update and set_assoc_cache_tag_lookup; no dependencies.
package sacl_pkg;

   localparam int SETS          = 256;
   localparam int WAYS          = 8;
   localparam int ADDR_BITS     = 64;
   localparam int SET_IDX_BITS  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int MAX_SET_BITS  = (SETS > 1) ? $clog2(SETS + 1) - 1 : 0;
   localparam int WAY_IDX_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RANK_BITS     = WAY_IDX_BITS;
   localparam int WAY_CNT_BITS  = 4;
   localparam int CNT_BITS      = 32;
   localparam int OUT_WAY_BITS  = 3;
   localparam int RSP_BITS      = 104;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 5;

   localparam logic [CSR_IDX_BITS-1:0] REG_SET_BITS     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_BLOCK_BITS   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_WAYS_IN_USE  = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_REPLACE_MODE = 2'd3;

   localparam logic MODE_FIFO = 1'b0;
   localparam logic MODE_LRU  = 1'b1;

   typedef struct packed {
      logic                 valid;
      logic [ADDR_BITS-1:0] tag;
      logic [RANK_BITS-1:0] rank;
   } way_entry_type;

   typedef way_entry_type [WAYS-1:0] row_type;

   typedef struct packed {
      logic                    hit;
      logic                    evicted;
      logic [WAY_IDX_BITS-1:0] way;
   } lookup_result_type;

endpackage

// ===== rtl/sacl_update.sv =====
// Tag compare and replacement for one set row: hit search, fill, victim choice, rank update.
// Depends on sacl_pkg.
module sacl_update (
   input  sacl_pkg::row_type                      row_in,
   input  logic [sacl_pkg::ADDR_BITS-1:0]         tag,
   input  logic [sacl_pkg::WAY_CNT_BITS-1:0]      ways,
   input  logic                                   lru,
   output sacl_pkg::row_type                      row_out,
   output sacl_pkg::lookup_result_type            result
);
   import sacl_pkg::*;

   logic                    hit;
   logic                    found_free;
   logic [WAY_IDX_BITS-1:0] hit_way;
   logic [WAY_IDX_BITS-1:0] free_way;
   logic [WAY_IDX_BITS-1:0] old_way;
   logic [RANK_BITS-1:0]    best;
   logic [WAY_IDX_BITS-1:0] way;
   logic                    was_valid;
   logic                    do_update;
   logic [RANK_BITS-1:0]    sel_rank;

   always_comb begin
      hit        = 1'b0;
      found_free = 1'b0;
      hit_way    = '0;
      free_way   = '0;
      old_way    = '0;
      best       = row_in[0].rank;
      for (int i = 0; i < WAYS; i++) begin
         if (WAY_CNT_BITS'(i) < ways) begin
            if (!hit && row_in[i].valid && row_in[i].tag == tag) begin
               hit     = 1'b1;
               hit_way = WAY_IDX_BITS'(i);
            end
            if (!found_free && !row_in[i].valid) begin
               found_free = 1'b1;
               free_way   = WAY_IDX_BITS'(i);
            end
            if (i != 0 && row_in[i].rank > best) begin
               best    = row_in[i].rank;
               old_way = WAY_IDX_BITS'(i);
            end
         end
      end

      way       = hit ? hit_way : (found_free ? free_way : old_way);
      was_valid = hit || !found_free;
      do_update = !hit || (lru == MODE_LRU);
      sel_rank  = row_in[way].rank;

      row_out = row_in;
      if (do_update) begin
         for (int i = 0; i < WAYS; i++) begin
            if (WAY_IDX_BITS'(i) != way && row_in[i].valid) begin
               if (!was_valid || row_in[i].rank < sel_rank) begin
                  row_out[i].rank = row_in[i].rank + RANK_BITS'(1);
               end
            end
         end
         row_out[way].rank = '0;
      end
      if (!hit) begin
         row_out[way].valid = 1'b1;
         row_out[way].tag   = tag;
      end

      result.hit     = hit;
      result.evicted = !hit && !found_free;
      result.way     = way;
   end

endmodule

// ===== rtl/set_assoc_cache_tag_lookup.sv =====
// Top level of the set-associative cache tag lookup with LRU or FIFO replacement.
// Depends on sacl_pkg and sacl_update.
//
//   Channel   Direction   Beat contents
//   req_*     in          tdata[63:0] address
//   rsp_*     out         tdata hit, evicted, way_used, hit_total, miss_total, eviction_total
//   csr_*     in          csr_index register number, csr_wdata value
//
// For each address the set row is read from the tag memory into a register on acceptance,
// then compared, updated and written back in the lookup state. Reset clears the per-row
// valid flags at once, so no clearing pass is needed. A full result register stalls the
// write-back cycle; a new address is accepted while the last result waits.
module set_assoc_cache_tag_lookup (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [63:0]                          req_tdata,   // address
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // hit, evicted, way_used[2:0], hit_total, miss_total, eviction_total, zero pad
   output logic [sacl_pkg::RSP_BITS-1:0]        rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sacl_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [sacl_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import sacl_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LOOK = 1'b1;

   localparam int SHIFT_BITS = 6;

   logic                    state_ff, state_in;
   logic [3:0]              set_bits_ff;
   logic [4:0]              block_bits_ff;
   logic [3:0]              ways_in_use_ff;
   logic                    replace_mode_ff;

   row_type                 mem [SETS];
   row_type                 rd_data_ff;
   logic [SETS-1:0]         row_valid_ff;
   logic                    row_seen_ff;
   logic [SET_IDX_BITS-1:0] set_ff, set_in;
   logic [ADDR_BITS-1:0]    tag_ff, tag_in;

   logic [CNT_BITS-1:0]     hits_ff, misses_ff, evicts_ff;
   logic [CNT_BITS-1:0]     hits_in, misses_in, evicts_in;
   logic                    rsp_valid_ff;
   logic [RSP_BITS-1:0]     rsp_data_ff, rsp_data_in;

   logic                    accept;
   logic                    advance;
   logic [ADDR_BITS-1:0]    addr;
   logic [3:0]              sb;
   logic [SHIFT_BITS-1:0]   tag_shift;
   logic [ADDR_BITS-1:0]    set_shifted;
   logic [SET_IDX_BITS:0]   set_mask;
   logic [WAY_CNT_BITS-1:0] ways_eff;
   row_type                 row_cur;
   row_type                 row_new;
   lookup_result_type       res;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign advance    = (state_ff == ST_LOOK) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      addr        = req_tdata[ADDR_BITS-1:0];
      sb          = (set_bits_ff > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : set_bits_ff;
      tag_shift   = SHIFT_BITS'(sb) + SHIFT_BITS'(block_bits_ff);
      set_shifted = addr >> block_bits_ff;
      set_mask    = ((SET_IDX_BITS+1)'(1) << sb) - (SET_IDX_BITS+1)'(1);
      set_in      = set_shifted[SET_IDX_BITS-1:0] & set_mask[SET_IDX_BITS-1:0];
      tag_in      = addr >> tag_shift;
      if (ways_in_use_ff == '0) begin
         ways_eff = WAY_CNT_BITS'(1);
      end else if (ways_in_use_ff > WAY_CNT_BITS'(WAYS)) begin
         ways_eff = WAY_CNT_BITS'(WAYS);
      end else begin
         ways_eff = ways_in_use_ff;
      end
   end

   always_comb begin
      row_cur = rd_data_ff;
      if (!row_seen_ff) begin
         for (int i = 0; i < WAYS; i++) begin
            row_cur[i].valid = 1'b0;
         end
      end
   end

   sacl_update u_update (
      .row_in  (row_cur),
      .tag     (tag_ff),
      .ways    (ways_eff),
      .lru     (replace_mode_ff),
      .row_out (row_new),
      .result  (res)
   );

   always_comb begin
      hits_in   = hits_ff;
      misses_in = misses_ff;
      evicts_in = evicts_ff;
      if (res.hit) begin
         if (hits_ff != '1) hits_in = hits_ff + CNT_BITS'(1);
      end else begin
         if (misses_ff != '1) misses_in = misses_ff + CNT_BITS'(1);
      end
      if (res.evicted && evicts_ff != '1) begin
         evicts_in = evicts_ff + CNT_BITS'(1);
      end
      rsp_data_in = {3'b000, evicts_in, misses_in, hits_in,
                     OUT_WAY_BITS'(res.way), res.evicted, res.hit};
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if (advance) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff  <= mem[set_in];
         row_seen_ff <= row_valid_ff[set_in];
         set_ff      <= set_in;
         tag_ff      <= tag_in;
      end
      if (advance) begin
         mem[set_ff] <= row_new;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         row_valid_ff    <= '0;
         hits_ff         <= '0;
         misses_ff       <= '0;
         evicts_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
         set_bits_ff     <= 4'd0;
         block_bits_ff   <= 5'd4;
         ways_in_use_ff  <= 4'd8;
         replace_mode_ff <= MODE_LRU;
      end else begin
         state_ff <= state_in;
         if (advance) begin
            row_valid_ff[set_ff] <= 1'b1;
            hits_ff              <= hits_in;
            misses_ff            <= misses_in;
            evicts_ff            <= evicts_in;
            rsp_valid_ff         <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SET_BITS:     set_bits_ff     <= csr_wdata[3:0];
               REG_BLOCK_BITS:   block_bits_ff   <= csr_wdata[4:0];
               REG_WAYS_IN_USE:  ways_in_use_ff  <= csr_wdata[3:0];
               REG_REPLACE_MODE: replace_mode_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

endmodule
